@@ rtl/rblmc_pkg.sv @@
// shared types, constants and color table for the breathing led mode controller
`timescale 1ns / 1ps
package rblmc_pkg;

   localparam int PWM_STEPS   = 1000;
   localparam int COLOR_SLOTS = 7;
   localparam int MS_PER_SEC  = 1000;
   localparam int DIV_STEPS   = 32;

   // register indexes on the csr port
   localparam logic [2:0] REG_BREATH_PERIOD = 3'd0;
   localparam logic [2:0] REG_SOLID_PERIOD  = 3'd1;
   localparam logic [2:0] REG_BLINK_HALF    = 3'd2;
   localparam logic [2:0] REG_LONG_PRESS    = 3'd3;
   localparam logic [2:0] REG_BUTTON_DEB    = 3'd4;
   localparam logic [2:0] REG_TOUCH_DEB     = 3'd5;
   localparam logic [2:0] REG_IDLE_TIMEOUT  = 3'd6;

   typedef enum logic [1:0] {
      MODE_BREATH = 2'd0,
      MODE_STEADY = 2'd1,
      MODE_BLINK  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      LED_OFF, LED_SOLID, LED_BLINK, LED_BREATH
   } led_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_UPDATE, ST_PREP, ST_DIV, ST_SHADE
   } state_type;

   typedef struct packed {
      logic [15:0] breath_period;
      logic [15:0] solid_period;
      logic [15:0] blink_half;
      logic [15:0] long_press;
      logic [9:0]  button_debounce;
      logic [15:0] touch_debounce;
      logic [15:0] idle_timeout;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic update;
      logic prep;
      logic div_step;
      logic shade;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
      logic out_free;
   } status_type;

   // percent of full level per color slot and channel (0 red, 1 green, 2 blue)
   function automatic logic [6:0] hue_pct(input logic [2:0] slot, input logic [1:0] ch);
      logic [20:0] row;
      case (slot)
         3'd0:    row = {7'd0,   7'd0,   7'd100};
         3'd1:    row = {7'd0,   7'd50,  7'd50};
         3'd2:    row = {7'd0,   7'd100, 7'd0};
         3'd3:    row = {7'd50,  7'd50,  7'd0};
         3'd4:    row = {7'd100, 7'd0,   7'd0};
         3'd5:    row = {7'd50,  7'd0,   7'd50};
         3'd6:    row = {7'd33,  7'd33,  7'd33};
         default: row = 21'd0;
      endcase
      case (ch)
         2'd0:    hue_pct = row[6:0];
         2'd1:    hue_pct = row[13:7];
         2'd2:    hue_pct = row[20:14];
         default: hue_pct = 7'd0;
      endcase
   endfunction

   // pct * level / 100, floor; 33 percent by a reciprocal multiply
   function automatic logic [9:0] scale_pct(input logic [6:0] pct, input logic [9:0] level);
      logic [24:0] prod;
      prod = 25'(level) * 25'd21627;
      case (pct)
         7'd100:  scale_pct = level;
         7'd50:   scale_pct = {1'b0, level[9:1]};
         7'd33:   scale_pct = prod[25-1:16] > 9'd0 ? 10'(prod[24:16]) : 10'd0;
         default: scale_pct = 10'd0;
      endcase
   endfunction

endpackage

@@ rtl/rblmc_csr.sv @@
// csr register file with apb-style write and read
`timescale 1ns / 1ps
module rblmc_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output rblmc_pkg::cfg_type   cfg
);
   import rblmc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;
   logic [2:0] idx;

   assign idx   = csr_paddr[4:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign cfg   = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_BREATH_PERIOD: cfg_in.breath_period   = csr_pwdata[15:0];
            REG_SOLID_PERIOD:  cfg_in.solid_period    = csr_pwdata[15:0];
            REG_BLINK_HALF:    cfg_in.blink_half      = csr_pwdata[15:0];
            REG_LONG_PRESS:    cfg_in.long_press      = csr_pwdata[15:0];
            REG_BUTTON_DEB:    cfg_in.button_debounce = csr_pwdata[9:0];
            REG_TOUCH_DEB:     cfg_in.touch_debounce  = csr_pwdata[15:0];
            REG_IDLE_TIMEOUT:  cfg_in.idle_timeout    = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.breath_period   <= 16'd2000;
         cfg_ff.solid_period    <= 16'd1000;
         cfg_ff.blink_half      <= 16'd100;
         cfg_ff.long_press      <= 16'd5000;
         cfg_ff.button_debounce <= 10'd20;
         cfg_ff.touch_debounce  <= 16'd300;
         cfg_ff.idle_timeout    <= 16'd300;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (idx)
         REG_BREATH_PERIOD: csr_prdata = {16'd0, cfg_ff.breath_period};
         REG_SOLID_PERIOD:  csr_prdata = {16'd0, cfg_ff.solid_period};
         REG_BLINK_HALF:    csr_prdata = {16'd0, cfg_ff.blink_half};
         REG_LONG_PRESS:    csr_prdata = {16'd0, cfg_ff.long_press};
         REG_BUTTON_DEB:    csr_prdata = {22'd0, cfg_ff.button_debounce};
         REG_TOUCH_DEB:     csr_prdata = {16'd0, cfg_ff.touch_debounce};
         REG_IDLE_TIMEOUT:  csr_prdata = {16'd0, cfg_ff.idle_timeout};
         default:           csr_prdata = 32'd0;
      endcase
   end

endmodule

@@ rtl/rblmc_datapath.sv @@
// tick state, button and touch logic, serial divider and output register
`timescale 1ns / 1ps
module rblmc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  rblmc_pkg::cfg_type     cfg,
   input  rblmc_pkg::cmd_type     cmd,
   output rblmc_pkg::status_type  status,
   input  logic                   in_button,
   input  logic                   in_touch,
   input  logic                   out_ready,
   output logic                   out_valid,
   output logic [39:0]            out_data
);
   import rblmc_pkg::*;

   logic [31:0] now_ff, now_in, cs_ff, cs_in, ps_ff, ps_in, tl_ff, tl_in;
   logic [2:0]  pos_ff, pos_in;
   mode_type    mode_ff, mode_in;
   logic        held_ff, held_in, prevb_ff, prevb_in, asleep_ff, asleep_in;
   logic [9:0]  sub_ff, sub_in;
   logic [15:0] secs_ff, secs_in;
   logic        btn_ff, btn_in, touch_ff, touch_in;
   led_type     kind_ff, kind_in;
   logic [15:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [31:0] quot_ff, quot_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [9:0]  red_ff, red_in, grn_ff, grn_in, blu_ff, blu_in;
   logic [1:0]  omode_ff, omode_in;
   logic [2:0]  oslot_ff, oslot_in;
   logic        osleep_ff, osleep_in, valid_ff, valid_in;

   logic        press, release_e, out_free;
   logic [16:0] rem_n;
   logic [15:0] el16, half, tri_v;
   logic [31:0] el;
   logic [25:0] num;
   logic [9:0]  level;

   assign press     = !prevb_ff && btn_ff;
   assign release_e = prevb_ff && !btn_ff;
   assign out_free  = !valid_ff || out_ready;
   assign rem_n     = {rem_ff, quot_ff[31]};

   assign status.need_div = (kind_ff == LED_BLINK) || (kind_ff == LED_BREATH);
   assign status.div_done = (cnt_ff == 5'(DIV_STEPS - 1));
   assign status.out_free = out_free;

   assign out_valid = valid_ff;
   assign out_data  = {4'd0, osleep_ff, oslot_ff, omode_ff, blu_ff, grn_ff, red_ff};

   always_comb begin
      now_in = now_ff; cs_in = cs_ff; ps_in = ps_ff; tl_in = tl_ff;
      pos_in = pos_ff; mode_in = mode_ff; held_in = held_ff; prevb_in = prevb_ff;
      asleep_in = asleep_ff; sub_in = sub_ff; secs_in = secs_ff;
      btn_in = btn_ff; touch_in = touch_ff; kind_in = kind_ff;
      rem_in = rem_ff; dvs_in = dvs_ff; quot_in = quot_ff; cnt_in = cnt_ff;
      red_in = red_ff; grn_in = grn_ff; blu_in = blu_ff;
      omode_in = omode_ff; oslot_in = oslot_ff; osleep_in = osleep_ff;
      valid_in = valid_ff;
      el = 32'd0; el16 = 16'd0; tri_v = 16'd0; num = 26'd0; level = 10'd0;
      half = (cfg.breath_period[15:1] == 15'd0) ? 16'd1 : {1'b0, cfg.breath_period[15:1]};

      // capture input beat
      if (cmd.load) begin
         btn_in   = in_button;
         touch_in = in_touch;
      end

      // wake, button edges, touch and idle count
      if (cmd.update) begin
         prevb_in = btn_ff;
         if (!(asleep_ff && !press)) begin
            if (asleep_ff) begin
               asleep_in = 1'b0; secs_in = 16'd0; sub_in = 10'd0; cs_in = now_ff;
            end
            if (press || release_e) secs_in = 16'd0;
            if (press && (now_ff - ps_ff) >= {22'd0, cfg.button_debounce}) begin
               ps_in   = now_ff;
               held_in = 1'b1;
            end
            if (release_e && held_ff) begin
               held_in = 1'b0;
               if ((now_ff - ps_in) >= {16'd0, cfg.long_press}) begin
                  if (mode_ff == MODE_BLINK) begin
                     mode_in = MODE_BREATH; pos_in = 3'd0; cs_in = now_ff;
                  end else begin
                     mode_in = MODE_BLINK;
                  end
               end
            end
            if (mode_in != MODE_BLINK && touch_ff &&
                (now_ff - tl_ff) >= {16'd0, cfg.touch_debounce}) begin
               tl_in   = now_ff;
               secs_in = 16'd0;
               mode_in = (mode_in == MODE_BREATH) ? MODE_STEADY : MODE_BREATH;
               pos_in  = 3'd0;
               cs_in   = now_ff;
            end
            sub_in = sub_in + 10'd1;
            if (sub_in >= 10'(MS_PER_SEC)) begin
               sub_in = 10'd0;
               if (secs_in != 16'hFFFF) secs_in = secs_in + 16'd1;
            end
            if (secs_in >= cfg.idle_timeout) asleep_in = 1'b1;
         end
      end

      // led preparation and divider setup
      if (cmd.prep) begin
         now_in = now_ff + 32'd1;
         rem_in = 16'd0;
         cnt_in = 5'd0;
         if (asleep_ff) begin
            kind_in = LED_OFF;
         end else if (mode_ff == MODE_STEADY) begin
            kind_in = LED_SOLID;
            if ((now_ff - cs_ff) >= {16'd0, cfg.solid_period}) begin
               pos_in = (pos_ff == 3'(COLOR_SLOTS - 1)) ? 3'd0 : pos_ff + 3'd1;
               cs_in  = now_ff;
            end
         end else if (mode_ff == MODE_BLINK) begin
            kind_in = LED_BLINK;
            quot_in = now_ff;
            dvs_in  = (cfg.blink_half == 16'd0) ? 16'd1 : cfg.blink_half;
         end else begin
            kind_in = LED_BREATH;
            el = now_ff - cs_ff;
            if (el >= {16'd0, cfg.breath_period}) begin
               pos_in = (pos_ff == 3'(COLOR_SLOTS - 1)) ? 3'd0 : pos_ff + 3'd1;
               cs_in  = now_ff;
               el16   = 16'd0;
            end else begin
               el16 = el[15:0];
            end
            tri_v   = (el16 < half) ? el16 : cfg.breath_period - el16;
            num     = 26'(tri_v) * 26'(PWM_STEPS);
            quot_in = {6'd0, num};
            dvs_in  = half;
         end
      end

      // one restoring divide step
      if (cmd.div_step) begin
         cnt_in = cnt_ff + 5'd1;
         if (rem_n >= {1'b0, dvs_ff}) begin
            rem_in  = 16'(rem_n - {1'b0, dvs_ff});
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_n[15:0];
            quot_in = {quot_ff[30:0], 1'b0};
         end
      end

      // color shading into output register
      if (cmd.shade) begin
         case (kind_ff)
            LED_SOLID:  level = 10'(PWM_STEPS);
            LED_BREATH: level = (quot_ff > 32'(PWM_STEPS)) ? 10'(PWM_STEPS) : quot_ff[9:0];
            default:    level = 10'd0;
         endcase
         if (kind_ff == LED_BLINK) begin
            red_in = quot_ff[0] ? 10'(PWM_STEPS) : 10'd0;
            grn_in = 10'(PWM_STEPS);
            blu_in = 10'(PWM_STEPS);
         end else begin
            red_in = 10'(PWM_STEPS) - scale_pct(hue_pct(pos_ff, 2'd0), level);
            grn_in = 10'(PWM_STEPS) - scale_pct(hue_pct(pos_ff, 2'd1), level);
            blu_in = 10'(PWM_STEPS) - scale_pct(hue_pct(pos_ff, 2'd2), level);
         end
         omode_in  = mode_ff;
         oslot_in  = pos_ff;
         osleep_in = asleep_ff;
         valid_in  = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= 32'd0; cs_ff <= 32'd0; ps_ff <= 32'd0; tl_ff <= 32'd0;
         pos_ff <= 3'd0; mode_ff <= MODE_BREATH; held_ff <= 1'b0; prevb_ff <= 1'b0;
         asleep_ff <= 1'b0; sub_ff <= 10'd0; secs_ff <= 16'd0;
         kind_ff <= LED_OFF; cnt_ff <= 5'd0; valid_ff <= 1'b0;
      end else begin
         now_ff <= now_in; cs_ff <= cs_in; ps_ff <= ps_in; tl_ff <= tl_in;
         pos_ff <= pos_in; mode_ff <= mode_in; held_ff <= held_in; prevb_ff <= prevb_in;
         asleep_ff <= asleep_in; sub_ff <= sub_in; secs_ff <= secs_in;
         kind_ff <= kind_in; cnt_ff <= cnt_in; valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      btn_ff <= btn_in; touch_ff <= touch_in;
      rem_ff <= rem_in; dvs_ff <= dvs_in; quot_ff <= quot_in;
      red_ff <= red_in; grn_ff <= grn_in; blu_ff <= blu_in;
      omode_ff <= omode_in; oslot_ff <= oslot_in; osleep_ff <= osleep_in;
   end

endmodule

@@ rtl/rblmc_ctrl.sv @@
// sequencing state machine for one tick
`timescale 1ns / 1ps
module rblmc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rblmc_pkg::status_type  status,
   output rblmc_pkg::cmd_type     cmd
);
   import rblmc_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (in_valid) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_PREP;
         ST_PREP:   state_in = ST_DIV;
         ST_DIV:    if (!status.need_div || status.div_done) state_in = ST_SHADE;
         ST_SHADE:  if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         ST_UPDATE: cmd.update   = 1'b1;
         ST_PREP:   cmd.prep     = 1'b1;
         ST_DIV:    cmd.div_step = status.need_div;
         ST_SHADE:  cmd.shade    = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/rgb_breathing_led_mode_controller.sv @@
// top level of the rgb breathing led mode controller
// a breathing or blink tick runs update, prep, a 32-step serial divider and shade; solid
// and sleep ticks take no divide steps, and shade waits while the output is stalled
// a new beat is taken only once the previous tick has been shaded into the output register
// a finished result waits in the output register while the next beat is taken
// reset: synchronous active high, clears all tick state and loads register defaults
`timescale 1ns / 1ps
module rgb_breathing_led_mode_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // button_level, touch_seen
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // red_compare, green_compare, blue_compare,
                                    // run_mode, color_slot, sleeping
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rblmc_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;

   // register file
   rblmc_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite,
      .csr_paddr, .csr_pwdata, .csr_prdata, .cfg
   );

   // controller
   rblmc_ctrl u_ctrl (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .status, .cmd
   );

   // datapath
   rblmc_datapath u_dp (
      .clock, .reset, .cfg, .cmd, .status,
      .in_button(req_tdata[0]), .in_touch(req_tdata[1]),
      .out_ready(rsp_tready), .out_valid(rsp_tvalid), .out_data(rsp_tdata)
   );

endmodule

@@ rtl/rblmc_checker.sv @@
// port-level checks for the controller, bound to the top level
`timescale 1ns / 1ps
module rblmc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        csr_pready
);
   // stalled result beat stays up
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   // sleeping beats show all leds off
   a_sleep_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |->
         rsp_tdata[9:0] == 10'd1000 && rsp_tdata[19:10] == 10'd1000 &&
         rsp_tdata[29:20] == 10'd1000)
      else $error("leds lit while sleeping");

   // compares never exceed the pwm range and the color slot stays in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9:0] <= 10'd1000 && rsp_tdata[19:10] <= 10'd1000 &&
         rsp_tdata[29:20] <= 10'd1000 && rsp_tdata[34:32] <= 3'd6)
      else $error("compare or color out of range");

   // csr port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr pready low");

endmodule

bind rgb_breathing_led_mode_controller rblmc_checker u_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_pready
);
